// ===== sv/lrukv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
`default_nettype none
package lrukv_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RANK_W      = IDX_W;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef struct packed {
        logic                           operation;
        logic signed [KEY_WIDTH-1:0]    lookup_key;
        logic signed [VALUE_WIDTH-1:0]  write_value;
    } cmd_t;

    typedef struct packed {
        logic                           hit;
        logic signed [VALUE_WIDTH-1:0]  read_value;
        logic                           evicted;
        logic signed [KEY_WIDTH-1:0]    evicted_key;
    } result_t;

endpackage
`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Usage: present a command on cmd and raise start; it is taken at a rising
// edge where start is high and busy is low. busy stays high while the
// command is worked on and no new command is taken.
// A command passes these steps from transfer to result: one key comparator
// walks the 16 entries of the key RAM one per cycle in S_SCAN, S_DRAIN
// compares the last entry read, S_EXEC decides and updates, S_VREAD reads
// the value RAM on a get that hits, and the result is registered.
// The result appears on result for exactly one cycle with done high; the
// receiver cannot stall it. A get miss or a set skips S_VREAD.
// busy is already low in the cycle done is high, so a new command can be
// taken as soon as done is high.
// Recency ranks are updated for all entries at once in the decide cycle.
// capacity_we writes capacity_wdata into the capacity register, to be used
// only while busy is low and no result is pending.
// Reset clears the valid marks, the entry count and sets capacity to 16;
// key and value RAM contents are left as they are, gated by the valid marks.
`default_nettype none
module lru_key_value_cache (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire lrukv_pkg::cmd_t          cmd,
    output logic                          done,
    output lrukv_pkg::result_t            result,
    input  wire logic                     capacity_we,
    input  wire logic [lrukv_pkg::CAP_W-1:0] capacity_wdata
);

    import lrukv_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_VREAD = 3'd4;

    logic [2:0]             state_reg, state_next;
    cmd_t                   cmd_reg;
    logic [CAP_W-1:0]       capacity_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   valid_reg [DEPTH];
    logic                   valid_next [DEPTH];
    logic [RANK_W-1:0]      rank_reg [DEPTH];
    logic [RANK_W-1:0]      rank_next [DEPTH];

    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   cmp_valid_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;

    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       found_idx_reg, found_idx_next;
    logic                   free_reg, free_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   old_reg, old_next;
    logic [IDX_W-1:0]       old_idx_reg, old_idx_next;
    logic [RANK_W-1:0]      old_rank_reg, old_rank_next;
    logic [KEY_WIDTH-1:0]   old_key_reg, old_key_next;

    logic                   done_reg, done_next;
    result_t                result_reg, result_next;

    logic                   key_we;
    logic [IDX_W-1:0]       key_addr;
    logic [KEY_WIDTH-1:0]   key_wdata, key_rdata;
    logic                   val_we;
    logic [IDX_W-1:0]       val_addr;
    logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

    logic [CNT_W-1:0]       cap_eff;
    logic                   do_evict;
    logic                   do_fill;
    logic [IDX_W-1:0]       slot;
    logic [RANK_W-1:0]      touch_rank;

    lrukv_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .addr  (key_addr),
        .wdata (key_wdata),
        .rdata (key_rdata)
    );

    lrukv_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .addr  (val_addr),
        .wdata (val_wdata),
        .rdata (val_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (int'(capacity_reg) > DEPTH)
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(capacity_reg);
        end
    end

    assign do_evict   = ((count_reg >= cap_eff) || !free_reg) && old_reg;
    assign do_fill    = do_evict || free_reg;
    assign slot       = do_evict ? old_idx_reg : free_idx_reg;
    assign touch_rank = rank_reg[found_idx_reg];

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        old_next       = old_reg;
        old_idx_next   = old_idx_reg;
        old_rank_next  = old_rank_reg;
        old_key_next   = old_key_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        key_we         = 1'b0;
        key_addr       = scan_idx_reg;
        key_wdata      = cmd_reg.lookup_key;
        val_we         = 1'b0;
        val_addr       = found_idx_reg;
        val_wdata      = cmd_reg.write_value;
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_next[i] = valid_reg[i];
            rank_next[i]  = rank_reg[i];
        end

        // Compare the entry whose key came out of the RAM this cycle
        if (cmp_valid_reg)
        begin
            if (valid_reg[cmp_idx_reg])
            begin
                if (!found_reg && (key_rdata == cmd_reg.lookup_key))
                begin
                    found_next     = 1'b1;
                    found_idx_next = cmp_idx_reg;
                end
                if (!old_reg || (rank_reg[cmp_idx_reg] > old_rank_reg))
                begin
                    old_next      = 1'b1;
                    old_idx_next  = cmp_idx_reg;
                    old_rank_next = rank_reg[cmp_idx_reg];
                    old_key_next  = key_rdata;
                end
            end
            else if (!free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    old_next      = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                result_next.hit         = found_reg;
                result_next.read_value  = '0;
                result_next.evicted     = 1'b0;
                result_next.evicted_key = '0;
                if (found_reg)
                begin
                    // Move the entry to most recent; younger entries age by one
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (valid_reg[i] && (rank_reg[i] < touch_rank))
                        begin
                            rank_next[i] = rank_reg[i] + 1'b1;
                        end
                    end
                    rank_next[found_idx_reg] = '0;
                end
                if (cmd_reg.operation == OP_GET)
                begin
                    if (found_reg)
                    begin
                        state_next = S_VREAD;
                    end
                    else
                    begin
                        result_next.read_value = '1;
                        done_next              = 1'b1;
                        state_next             = S_IDLE;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        val_we = 1'b1;
                    end
                    else if (do_fill)
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (valid_reg[i])
                            begin
                                rank_next[i] = rank_reg[i] + 1'b1;
                            end
                        end
                        rank_next[slot]  = '0;
                        valid_next[slot] = 1'b1;
                        key_we           = 1'b1;
                        key_addr         = slot;
                        val_we           = 1'b1;
                        val_addr         = slot;
                        if (do_evict)
                        begin
                            result_next.evicted     = 1'b1;
                            result_next.evicted_key = old_key_reg;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_VREAD:
            begin
                result_next.read_value = val_rdata;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= (state_reg == S_SCAN);
            done_reg      <= done_next;
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            cmd_reg <= cmd;
        end
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= scan_idx_reg;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        old_reg       <= old_next;
        old_idx_reg   <= old_idx_next;
        old_rank_reg  <= old_rank_next;
        old_key_reg   <= old_key_next;
        result_reg    <= result_next;
        for (int i = 0; i < DEPTH; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
    end

endmodule
`default_nettype wire

// ===== sv/lrukv_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module lrukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                          wdata,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule
`default_nettype wire
